// File: src/bmsi_pkg.sv
// shared types and constants for the bank mapper with scanline irq
// no dependencies

package bmsi_pkg;

    localparam int CHR_SLOTS = 8;
    localparam int SLOT_W = $clog2(CHR_SLOTS);

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_PRG   = 2'd2,
        ACT_CHR   = 2'd3
    } action_t;

    // configuration register indexes
    localparam logic [1:0] CFG_LINE_A    = 2'd0;
    localparam logic [1:0] CFG_LINE_B    = 2'd1;
    localparam logic [1:0] CFG_PRG_LAST  = 2'd2;

    // top nibble of a register write address
    localparam logic [3:0] NIB_PRG0      = 4'h8;
    localparam logic [3:0] NIB_MIRROR    = 4'h9;
    localparam logic [3:0] NIB_PRG1      = 4'hA;
    localparam logic [3:0] NIB_CHR_FIRST = 4'hB;
    localparam logic [3:0] NIB_CHR_LAST  = 4'hE;
    localparam logic [3:0] NIB_IRQ       = 4'hF;

    // register select codes within the irq nibble
    localparam logic [1:0] SEL_LATCH_LO  = 2'd0;
    localparam logic [1:0] SEL_LATCH_HI  = 2'd1;
    localparam logic [1:0] SEL_CONTROL   = 2'd2;
    localparam logic [1:0] SEL_ACK       = 2'd3;

    // irq_ctrl bits
    localparam int CTRL_ACK_EN = 0;
    localparam int CTRL_CYCLE  = 1;

    localparam logic [7:0] COUNTER_TOP   = 8'hFF;
    localparam logic [8:0] PRESC_LIMIT   = 9'd338;
    localparam logic [8:0] PRESC_INC     = 9'd3;

    typedef struct packed {
        action_t     action;
        logic [15:0] address;
        logic [7:0]  data;
    } item_t;

    typedef struct packed {
        action_t     action;
        logic [15:0] address;
        logic [7:0]  data;
        logic [1:0]  sel;
    } cmd_t;

endpackage

// File: src/bmsi_in_stage.sv
// input register stage holding one accepted item
// depends on bmsi_pkg

module bmsi_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  bmsi_pkg::item_t in_item,
    input  logic           advance,
    output logic           stage_valid,
    output bmsi_pkg::item_t stage_item
);

    logic            valid_reg;
    logic            valid_next;
    bmsi_pkg::item_t item_reg;
    logic            take;

    assign in_ready    = !valid_reg || advance;
    assign take        = in_valid && in_ready;
    assign valid_next  = take || (valid_reg && !advance);
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// File: src/bmsi_irq.sv
// irq latch, counter, scanline prescaler, control and pending flag
// depends on bmsi_pkg

module bmsi_irq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  bmsi_pkg::cmd_t cmd,
    output logic          pending_next
);

    logic [7:0] latch_reg;
    logic [7:0] latch_next;
    logic [7:0] counter_reg;
    logic [7:0] counter_next;
    logic [8:0] presc_reg;
    logic [8:0] presc_next;
    logic [1:0] ctrl_reg;
    logic [1:0] ctrl_next;
    logic       enabled_reg;
    logic       enabled_next;
    logic       pending_reg;
    logic       step;
    logic       irq_write;

    assign irq_write = cmd.address[15:12] == bmsi_pkg::NIB_IRQ;

    always_comb
    begin
        latch_next   = latch_reg;
        counter_next = counter_reg;
        presc_next   = presc_reg;
        ctrl_next    = ctrl_reg;
        enabled_next = enabled_reg;
        pending_next = pending_reg;
        step         = 1'b0;
        if (fire)
        begin
            case (cmd.action)
                bmsi_pkg::ACT_WRITE:
                begin
                    if (irq_write)
                    begin
                        case (cmd.sel)
                            bmsi_pkg::SEL_LATCH_LO:
                            begin
                                latch_next = {latch_reg[7:4], cmd.data[3:0]};
                            end
                            bmsi_pkg::SEL_LATCH_HI:
                            begin
                                latch_next = {cmd.data[3:0], latch_reg[3:0]};
                            end
                            bmsi_pkg::SEL_CONTROL:
                            begin
                                ctrl_next    = {cmd.data[2], cmd.data[0]};
                                enabled_next = cmd.data[1];
                                pending_next = 1'b0;
                                if (cmd.data[1])
                                begin
                                    presc_next   = '0;
                                    counter_next = latch_reg;
                                end
                            end
                            default:
                            begin
                                enabled_next = ctrl_reg[bmsi_pkg::CTRL_ACK_EN];
                                pending_next = 1'b0;
                            end
                        endcase
                    end
                end
                bmsi_pkg::ACT_TICK:
                begin
                    if (enabled_reg)
                    begin
                        step = 1'b1;
                        if (!ctrl_reg[bmsi_pkg::CTRL_CYCLE])
                        begin
                            if (presc_reg < bmsi_pkg::PRESC_LIMIT)
                            begin
                                presc_next = presc_reg + bmsi_pkg::PRESC_INC;
                                step       = 1'b0;
                            end
                            else
                            begin
                                presc_next = presc_reg - bmsi_pkg::PRESC_LIMIT;
                            end
                        end
                        if (step)
                        begin
                            if (counter_reg != bmsi_pkg::COUNTER_TOP)
                            begin
                                counter_next = counter_reg + 8'd1;
                            end
                            else
                            begin
                                counter_next = latch_reg;
                                pending_next = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    step = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg   <= '0;
            counter_reg <= '0;
            presc_reg   <= '0;
            ctrl_reg    <= '0;
            enabled_reg <= 1'b0;
            pending_reg <= 1'b0;
        end
        else
        begin
            latch_reg   <= latch_next;
            counter_reg <= counter_next;
            presc_reg   <= presc_next;
            ctrl_reg    <= ctrl_next;
            enabled_reg <= enabled_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// File: src/bmsi_map.sv
// program and character bank registers, mirroring and address translation
// depends on bmsi_pkg

module bmsi_map (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  bmsi_pkg::cmd_t cmd,
    input  logic [7:0]    prg_last_bank,
    output logic [7:0]    bank_next,
    output logic [1:0]    mirror_next
);

    logic [7:0] prg0_reg;
    logic [7:0] prg0_next;
    logic [7:0] prg1_reg;
    logic [7:0] prg1_next;
    logic       swap_reg;
    logic       swap_next;
    logic [1:0] mirror_reg;
    logic [7:0] chr_reg [bmsi_pkg::CHR_SLOTS];
    logic [7:0] chr_next [bmsi_pkg::CHR_SLOTS];
    logic [3:0] nib;
    logic [3:0] chr_off;
    logic [bmsi_pkg::SLOT_W-1:0] wr_slot;
    logic [bmsi_pkg::SLOT_W-1:0] rd_slot;
    logic [7:0] second_last;

    assign nib         = cmd.address[15:12];
    assign chr_off     = nib - bmsi_pkg::NIB_CHR_FIRST;
    assign wr_slot     = {chr_off[1:0], cmd.sel[1]};
    assign rd_slot     = cmd.address[10 +: bmsi_pkg::SLOT_W];
    assign second_last = prg_last_bank - 8'd1;

    always_comb
    begin
        prg0_next   = prg0_reg;
        prg1_next   = prg1_reg;
        swap_next   = swap_reg;
        mirror_next = mirror_reg;
        chr_next    = chr_reg;
        if (fire && cmd.action == bmsi_pkg::ACT_WRITE)
        begin
            if (nib == bmsi_pkg::NIB_PRG0)
            begin
                prg0_next = cmd.data;
            end
            else if (nib == bmsi_pkg::NIB_PRG1)
            begin
                prg1_next = cmd.data;
            end
            else if (nib == bmsi_pkg::NIB_MIRROR)
            begin
                if (!cmd.sel[1])
                begin
                    mirror_next = cmd.data[1:0];
                end
                else
                begin
                    swap_next = cmd.data[1];
                end
            end
            else if (nib inside {[bmsi_pkg::NIB_CHR_FIRST:bmsi_pkg::NIB_CHR_LAST]})
            begin
                if (cmd.sel[0])
                begin
                    chr_next[wr_slot] = {cmd.data[3:0], chr_reg[wr_slot][3:0]};
                end
                else
                begin
                    chr_next[wr_slot] = {chr_reg[wr_slot][7:4], cmd.data[3:0]};
                end
            end
        end
    end

    always_comb
    begin
        bank_next = '0;
        case (cmd.action)
            bmsi_pkg::ACT_PRG:
            begin
                if (cmd.address[15])
                begin
                    case (cmd.address[14:13])
                        2'd0:    bank_next = swap_reg ? second_last : prg0_reg;
                        2'd1:    bank_next = prg1_reg;
                        2'd2:    bank_next = swap_reg ? prg0_reg : second_last;
                        default: bank_next = prg_last_bank;
                    endcase
                end
            end
            bmsi_pkg::ACT_CHR:
            begin
                bank_next = chr_reg[rd_slot];
            end
            default:
            begin
                bank_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg0_reg   <= '0;
            prg1_reg   <= '0;
            swap_reg   <= 1'b0;
            mirror_reg <= '0;
            for (int i = 0; i < bmsi_pkg::CHR_SLOTS; i++)
            begin
                chr_reg[i] <= '0;
            end
        end
        else
        begin
            prg0_reg   <= prg0_next;
            prg1_reg   <= prg1_next;
            swap_reg   <= swap_next;
            mirror_reg <= mirror_next;
            chr_reg    <= chr_next;
        end
    end

endmodule

// File: src/bank_mapper_with_scanline_irq.sv
// top level: configuration registers, write select decode and result register
// depends on bmsi_pkg, bmsi_in_stage, bmsi_irq, bmsi_map
//
// usage
// - input channel (in_valid/in_ready) carries one cpu bus cycle per transfer:
//   action, address and data; every transfer gives exactly one result
// - output channel (out_valid/out_ready) returns irq level, mapped bank and
//   mirroring mode after that item
// - config channel (cfg_valid/cfg_ready) writes line_a, line_b, prg_last_bank by
//   index; cfg_ready is always high; the user must write only while idle (not enforced)
// - path: an accepted item passes the input register, then the result register
// - throughput: one item per cycle while the receiver keeps out_ready high, set by
//   the single state update between the input register and the result register
// - receiver stall: result and input registers both hold; in_ready falls only
//   once both are full
// - reset: all mapper and irq state clears to zero, line_a to 1, line_b to 0,
//   prg_last_bank to 31; both channels come up empty

module bank_mapper_with_scanline_irq (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        irq,
    output logic [7:0]  bank,
    output logic [1:0]  mirroring,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [2:0]      line_a_reg;
    logic [2:0]      line_b_reg;
    logic [7:0]      prg_last_reg;
    bmsi_pkg::item_t in_item;
    bmsi_pkg::item_t stage_item;
    bmsi_pkg::cmd_t  cmd;
    logic            stage_valid;
    logic            advance;
    logic            fire;
    logic            pending_next;
    logic [7:0]      bank_next;
    logic [1:0]      mirror_next;
    logic            out_valid_reg;
    logic            irq_reg;
    logic [7:0]      bank_reg;
    logic [1:0]      mirror_reg;

    assign cfg_ready = 1'b1;

    assign in_item.action  = bmsi_pkg::action_t'(action);
    assign in_item.address = address;
    assign in_item.data    = data;

    assign advance = !out_valid_reg || out_ready;
    assign fire    = stage_valid && advance;

    // register select from the two configured address lines
    assign cmd.action  = stage_item.action;
    assign cmd.address = stage_item.address;
    assign cmd.data    = stage_item.data;
    assign cmd.sel     = {stage_item.address[line_a_reg], stage_item.address[line_b_reg]};

    bmsi_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    bmsi_irq u_irq (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .cmd          (cmd),
        .pending_next (pending_next)
    );

    bmsi_map u_map (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .cmd           (cmd),
        .prg_last_bank (prg_last_reg),
        .bank_next     (bank_next),
        .mirror_next   (mirror_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_a_reg   <= 3'd1;
            line_b_reg   <= 3'd0;
            prg_last_reg <= 8'd31;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bmsi_pkg::CFG_LINE_A:   line_a_reg   <= cfg_data[2:0];
                bmsi_pkg::CFG_LINE_B:   line_b_reg   <= cfg_data[2:0];
                bmsi_pkg::CFG_PRG_LAST: prg_last_reg <= cfg_data;
                default:                prg_last_reg <= prg_last_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stage_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            irq_reg    <= pending_next;
            bank_reg   <= bank_next;
            mirror_reg <= mirror_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign irq       = irq_reg;
    assign bank      = bank_reg;
    assign mirroring = mirror_reg;

endmodule
